// ===== rtl/mwcm_pkg.sv =====
// mwcm_pkg: shared constants, types, sine table generator and microprogram
// for the mecanum wheel command mixer. no dependencies.
package mwcm_pkg;

  // field widths
  localparam int unsigned OP_W       = 2;
  localparam int unsigned HEAD_W     = 9;
  localparam int unsigned SPEED_W    = 7;
  localparam int unsigned PULSE_W    = 11;
  localparam int unsigned WHEELS     = 4;
  localparam int unsigned WHEEL_W    = 2;

  // command codes
  localparam logic [OP_W-1:0] OP_STOP = 2'd0;
  localparam logic [OP_W-1:0] OP_MOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_TURN = 2'd2;

  // servo and motion constants
  localparam int unsigned PULSE_MID    = 1500;
  localparam int unsigned PULSE_LOW    = 1000;
  localparam int unsigned PULSE_HIGH   = 2000;
  localparam int unsigned MOVE_GAIN    = 5;
  localparam int unsigned SPEED_FULL   = 100;
  localparam int unsigned MOVE_MAX     = MOVE_GAIN * SPEED_FULL;
  localparam int unsigned QUARTER_TURN = 90;
  localparam int unsigned HALF_TURN    = 180;
  localparam int unsigned FULL_TURN    = 360;

  // datapath sizing
  localparam int unsigned SINE_FRAC_BITS_DEFAULT = 15;
  localparam int unsigned SINE_DEPTH   = QUARTER_TURN + 1;
  localparam int unsigned SINE_IDX_W   = 7;
  localparam int unsigned GAIN_W       = 9;   // holds 5 * 100
  localparam int unsigned DIST_W       = 10;  // holds 1000
  localparam int unsigned QUOT_W       = 10;  // divider quotient bits

  // turn step divide by 100 as a reciprocal multiply:
  // exact floor for products up to 1000 * 100
  localparam int unsigned TURN_W       = 17;
  localparam int unsigned RECIP_W      = 18;
  localparam int unsigned RECIP_SHIFT  = 24;
  localparam int unsigned TURN_RECIP   = (1 << RECIP_SHIFT) / SPEED_FULL + 1;

  // sine table generation constants
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int unsigned     Q30_BITS = 30;

  // microprogram addressing
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] A_IDLE   = 4'd0;
  localparam logic [UPC_W-1:0] A_DISP   = 4'd1;
  localparam logic [UPC_W-1:0] A_STOP   = 4'd2;
  localparam logic [UPC_W-1:0] A_ANGLE  = 4'd3;
  localparam logic [UPC_W-1:0] A_SINE   = 4'd4;
  localparam logic [UPC_W-1:0] A_MUL    = 4'd5;
  localparam logic [UPC_W-1:0] A_DSTART = 4'd6;
  localparam logic [UPC_W-1:0] A_DWAIT  = 4'd7;
  localparam logic [UPC_W-1:0] A_WB     = 4'd8;
  localparam logic [UPC_W-1:0] A_DONE   = 4'd9;

  // datapath operation of one step
  typedef enum logic [3:0] {
    U_NONE,
    U_LATCH,
    U_DISPATCH,
    U_STOP,
    U_ANGLE,
    U_SINE,
    U_MUL,
    U_DSTART,
    U_WB,
    U_EMIT
  } uop_e;

  // sequencing of one step
  typedef enum logic [2:0] {
    J_NEXT,   // fall through
    J_GOTO,   // unconditional jump
    J_LOOP,   // jump while wheel counter not at last wheel
    J_BUSY,   // jump while divider busy
    J_IN,     // hold until a command transfer
    J_OUT,    // jump once the result register is free
    J_OP      // multiway branch on command code
  } jump_e;

  typedef struct packed {
    uop_e             uop;
    jump_e            jump;
    logic [UPC_W-1:0] target;
  } uword_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic rem_nz;
  } div_sts_t;

  // control store
  function automatic uword_t ucode(input logic [UPC_W-1:0] addr);
    uword_t w;
    case (addr)
      A_IDLE:   w = '{uop: U_LATCH,    jump: J_IN,   target: A_IDLE};
      A_DISP:   w = '{uop: U_DISPATCH, jump: J_OP,   target: A_IDLE};
      A_STOP:   w = '{uop: U_STOP,     jump: J_GOTO, target: A_DONE};
      A_ANGLE:  w = '{uop: U_ANGLE,    jump: J_NEXT, target: A_IDLE};
      A_SINE:   w = '{uop: U_SINE,     jump: J_LOOP, target: A_ANGLE};
      A_MUL:    w = '{uop: U_MUL,      jump: J_NEXT, target: A_IDLE};
      A_DSTART: w = '{uop: U_DSTART,   jump: J_NEXT, target: A_IDLE};
      A_DWAIT:  w = '{uop: U_NONE,     jump: J_BUSY, target: A_DWAIT};
      A_WB:     w = '{uop: U_WB,       jump: J_LOOP, target: A_MUL};
      A_DONE:   w = '{uop: U_EMIT,     jump: J_OUT,  target: A_IDLE};
      default:  w = '{uop: U_NONE,     jump: J_GOTO, target: A_IDLE};
    endcase
    return w;
  endfunction

  // mounting angle of each wheel, added to the heading
  function automatic logic [HEAD_W-1:0] wheel_offset(input logic [WHEEL_W-1:0] w);
    logic [HEAD_W-1:0] r;
    case (w)
      2'd0:    r = 9'd45;
      2'd1:    r = 9'd315;
      2'd2:    r = 9'd135;
      default: r = 9'd225;
    endcase
    return r;
  endfunction

  // sine table entry for d in 0..90 degrees, evaluated at elaboration only:
  // taylor series through x^17 in q30, rounded half up to frac bits
  function automatic longint unsigned sine_entry(input int unsigned d,
                                                 input int unsigned frac);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned s;
    longint unsigned term;
    int unsigned     sh;
    x    = (longint'(d) * PI_Q30) / HALF_TURN;
    x2   = (x * x) >> Q30_BITS;
    sh   = Q30_BITS - frac;
    // alternating terms, each step divides by (2k)(2k+1)
    term = ((x * x2) >> Q30_BITS) / 64'd6;
    s    = x - term;
    term = ((term * x2) >> Q30_BITS) / 64'd20;
    s    = s + term;
    term = ((term * x2) >> Q30_BITS) / 64'd42;
    s    = s - term;
    term = ((term * x2) >> Q30_BITS) / 64'd72;
    s    = s + term;
    term = ((term * x2) >> Q30_BITS) / 64'd110;
    s    = s - term;
    term = ((term * x2) >> Q30_BITS) / 64'd156;
    s    = s + term;
    term = ((term * x2) >> Q30_BITS) / 64'd210;
    s    = s - term;
    term = ((term * x2) >> Q30_BITS) / 64'd272;
    s    = s + term;
    return (s + (64'd1 << (sh - 1))) >> sh;
  endfunction

endpackage

// ===== rtl/mwcm_if.sv =====
// mwcm_cmd_if and mwcm_pulse_if: valid/ready channels for drive commands
// and wheel pulse results. depends on mwcm_pkg.
interface mwcm_cmd_if import mwcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      op;
  logic [HEAD_W-1:0]    heading_deg;
  logic [SPEED_W-1:0]   speed_pct;
  logic                 turn_left;

  modport source (output valid, op, heading_deg, speed_pct, turn_left, input ready);
  modport sink   (input valid, op, heading_deg, speed_pct, turn_left, output ready);
endinterface

interface mwcm_pulse_if import mwcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [PULSE_W-1:0]   front_left_us;
  logic [PULSE_W-1:0]   front_right_us;
  logic [PULSE_W-1:0]   back_left_us;
  logic [PULSE_W-1:0]   back_right_us;

  modport source (output valid, front_left_us, front_right_us, back_left_us,
                  back_right_us, input ready);
  modport sink   (input valid, front_left_us, front_right_us, back_left_us,
                  back_right_us, output ready);
endinterface

// ===== rtl/mwcm_div.sv =====
// mwcm_div: restoring unsigned divider, one quotient bit per cycle.
// depends on mwcm_pkg; dividend must be below divisor * 2^QW.
module mwcm_div import mwcm_pkg::*; #(
  parameter int unsigned DVD_W = SINE_FRAC_BITS_DEFAULT + GAIN_W,
  parameter int unsigned DVS_W = SINE_FRAC_BITS_DEFAULT + 1,
  parameter int unsigned QW    = QUOT_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic [QW-1:0]    quotient_o,
  output div_sts_t         sts_o
);

  localparam int unsigned CNT_W = $clog2(QW + 1);

  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [QW-1:0]    lo_q, lo_d;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             ge;

  // one trial subtract per cycle, quotient bits shift in behind the dividend
  assign trial = {rem_q, lo_q[QW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = (trial >= {1'b0, dvs_q});

  always_comb begin
    cnt_d = cnt_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    lo_d  = lo_q;
    if (start_i) begin
      cnt_d = CNT_W'(QW);
      rem_d = DVS_W'(dividend_i[DVD_W-1:QW]);
      lo_d  = dividend_i[QW-1:0];
      dvs_d = divisor_i;
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - 1'b1;
      rem_d = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
      lo_d  = {lo_q[QW-2:0], ge};
    end
  end

  // counter under reset, operands are payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    lo_q  <= lo_d;
  end

  assign quotient_o   = lo_q;
  assign sts_o.busy   = (cnt_q != '0);
  assign sts_o.rem_nz = (rem_q != '0);

endmodule

// ===== rtl/mecanum_wheel_command_mixer_core.sv =====
// mecanum_wheel_command_mixer_core: microcoded drive command mixer holding four
// wheel servo pulses. depends on mwcm_pkg, mwcm_if and mwcm_div.
//
//   port     dir  kind         carries
//   cmd_i    in   valid/ready  op, heading_deg, speed_pct, turn_left
//   pulse_o  out  valid/ready  front_left_us, front_right_us, back_left_us,
//                              back_right_us
//
// one command at a time. move runs the shared 10-step divider once per
// wheel, turn divides by 100 with a reciprocal multiply. reset puts all
// pulses at 1500.
// a result waits in its own register, so the next command is taken while the
// previous result stalls; the sequencer only holds at its final step when that
// register is still full.
module mecanum_wheel_command_mixer_core import mwcm_pkg::*; #(
  parameter int unsigned SINE_FRAC_BITS = SINE_FRAC_BITS_DEFAULT
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  mwcm_cmd_if.sink     cmd_i,
  mwcm_pulse_if.source pulse_o
);

  localparam int unsigned SW    = SINE_FRAC_BITS + 1;   // table magnitude
  localparam int unsigned VW    = SINE_FRAC_BITS + 2;   // signed wheel factor
  localparam int unsigned MW    = GAIN_W + 1;           // signed multiplier b side
  localparam int unsigned PW    = VW + MW;              // product
  localparam int unsigned DVD_W = SINE_FRAC_BITS + GAIN_W;
  localparam int unsigned RPW   = TURN_W + RECIP_W;     // reciprocal product

  // sine table, quarter wave
  logic [SW-1:0] sine_rom [SINE_DEPTH];

  for (genvar g = 0; g < SINE_DEPTH; g++) begin : g_rom
    localparam logic [SW-1:0] Val = SW'(sine_entry(g, SINE_FRAC_BITS));
    assign sine_rom[g] = Val;
  end

  // sequencer and datapath registers
  logic [UPC_W-1:0]      upc_q, upc_d;
  logic [WHEEL_W-1:0]    w_q, w_d;
  logic [OP_W-1:0]       op_q, op_d;
  logic [HEAD_W-1:0]     hmod_q, hmod_d;
  logic [SPEED_W-1:0]    spd_q, spd_d;
  logic                  left_q, left_d;
  logic [HEAD_W-1:0]     theta_q, theta_d;
  logic signed [VW-1:0]  v_q [WHEELS];
  logic signed [VW-1:0]  v_d [WHEELS];
  logic [SW-1:0]         mag_q, mag_d;
  logic signed [PW-1:0]  prod_q, prod_d;
  logic                  neg_q, neg_d;
  logic [QUOT_W-1:0]     tq_q, tq_d;
  logic [PULSE_W-1:0]    pulse_q [WHEELS];
  logic [PULSE_W-1:0]    pulse_d [WHEELS];
  logic [PULSE_W-1:0]    out_q [WHEELS];
  logic [PULSE_W-1:0]    out_d [WHEELS];
  logic                  out_valid_q, out_valid_d;

  uword_t                cw;
  logic                  cmd_fire;
  logic                  out_fire;
  logic                  emit;
  logic                  is_move;

  // divider hookup
  logic                  div_start;
  logic [DVD_W-1:0]      div_dvd;
  logic [SW-1:0]         div_dvs;
  logic [QUOT_W-1:0]     div_quot;
  div_sts_t              div_sts;

  // combinational helpers
  logic [HEAD_W-1:0]     hmod_n;
  logic [SPEED_W-1:0]    spd_n;
  logic [HEAD_W:0]       asum;
  logic [HEAD_W-1:0]     theta_n;
  logic [1:0]            quad;
  logic [HEAD_W-1:0]     rem9;
  logic [SINE_IDX_W-1:0] rr;
  logic [SINE_IDX_W-1:0] ridx;
  logic [SW-1:0]         sval;
  logic signed [VW-1:0]  vs;
  logic [DIST_W-1:0]     span;
  logic [GAIN_W-1:0]     gain;
  logic signed [VW-1:0]  mul_a;
  logic signed [MW-1:0]  mul_b;
  logic signed [PW-1:0]  mul_p;
  logic                  prod_neg;
  logic signed [PW-1:0]  prod_abs;
  logic [TURN_W-1:0]     tx;
  logic [RPW-1:0]        recip_p;
  logic [TURN_W-1:0]     tback;
  logic                  wb_rnz;
  logic [PULSE_W-1:0]    wb_base;
  logic [PULSE_W-1:0]    wb_q_ext;
  logic                  wb_sub;
  logic [PULSE_W-1:0]    wb_val;

  assign cw       = ucode(upc_q);
  assign cmd_fire = cmd_i.valid && cmd_i.ready;
  assign out_fire = pulse_o.valid && pulse_o.ready;
  assign is_move  = (op_q == OP_MOVE);

  assign cmd_i.ready = (upc_q == A_IDLE);

  // command field cleanup: heading wrap and speed clamp
  assign hmod_n = (cmd_i.heading_deg >= HEAD_W'(FULL_TURN)) ?
                  cmd_i.heading_deg - HEAD_W'(FULL_TURN) : cmd_i.heading_deg;
  assign spd_n  = (cmd_i.speed_pct > SPEED_W'(SPEED_FULL)) ?
                  SPEED_W'(SPEED_FULL) : cmd_i.speed_pct;

  // wheel angle, wrapped into one turn
  assign asum    = (HEAD_W + 1)'(hmod_q) + (HEAD_W + 1)'(wheel_offset(w_q));
  assign theta_n = (asum >= (HEAD_W + 1)'(FULL_TURN)) ?
                   HEAD_W'(asum - (HEAD_W + 1)'(FULL_TURN)) : asum[HEAD_W-1:0];

  // quadrant folding and table lookup
  always_comb begin
    if (theta_q < HEAD_W'(QUARTER_TURN)) begin
      quad = 2'd0;
      rem9 = theta_q;
    end else if (theta_q < HEAD_W'(HALF_TURN)) begin
      quad = 2'd1;
      rem9 = theta_q - HEAD_W'(QUARTER_TURN);
    end else if (theta_q < HEAD_W'(HALF_TURN + QUARTER_TURN)) begin
      quad = 2'd2;
      rem9 = theta_q - HEAD_W'(HALF_TURN);
    end else begin
      quad = 2'd3;
      rem9 = theta_q - HEAD_W'(HALF_TURN + QUARTER_TURN);
    end
  end

  assign rr   = rem9[SINE_IDX_W-1:0];
  assign ridx = quad[0] ? SINE_IDX_W'(QUARTER_TURN) - rr : rr;
  assign sval = sine_rom[ridx];
  assign vs   = quad[1] ? -signed'(VW'(sval)) : signed'(VW'(sval));

  // shared multiplier: wheel factor times gain, or distance times speed
  assign span  = left_q ? DIST_W'(pulse_q[w_q] - PULSE_W'(PULSE_LOW))
                        : DIST_W'(PULSE_W'(PULSE_HIGH) - pulse_q[w_q]);
  assign gain  = GAIN_W'(spd_q) * GAIN_W'(MOVE_GAIN);
  assign mul_a = is_move ? v_q[w_q] : signed'(VW'(span));
  assign mul_b = is_move ? signed'({1'b0, gain}) : signed'(MW'(spd_q));
  assign mul_p = mul_a * mul_b;

  // divider operands from the registered product
  assign prod_neg = prod_q[PW-1];
  assign prod_abs = prod_neg ? -prod_q : prod_q;
  assign div_dvd  = prod_abs[DVD_W-1:0];
  assign div_dvs  = (mag_q == '0) ? SW'(1) : mag_q;

  // turn step: divide by 100 through the reciprocal, remainder by multiply back
  assign tx      = prod_abs[TURN_W-1:0];
  assign recip_p = RPW'(tx) * RPW'(TURN_RECIP);
  assign tback   = TURN_W'(tq_q) * TURN_W'(SPEED_FULL);

  // writeback: floor for move and right turn, ceiling step for left turn
  assign wb_base  = is_move ? PULSE_W'(PULSE_MID) : pulse_q[w_q];
  assign wb_sub   = is_move ? neg_q : left_q;
  assign wb_q_ext = is_move ? PULSE_W'(div_quot) : PULSE_W'(tq_q);
  assign wb_rnz   = is_move ? div_sts.rem_nz : (tx != tback);
  assign wb_val   = wb_sub ? wb_base - wb_q_ext - PULSE_W'(wb_rnz)
                           : wb_base + wb_q_ext;

  // sequencer next address and datapath update
  always_comb begin
    upc_d       = upc_q;
    w_d         = w_q;
    op_d        = op_q;
    hmod_d      = hmod_q;
    spd_d       = spd_q;
    left_d      = left_q;
    theta_d     = theta_q;
    v_d         = v_q;
    mag_d       = mag_q;
    prod_d      = prod_q;
    neg_d       = neg_q;
    tq_d        = tq_q;
    pulse_d     = pulse_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_fire;
    div_start   = 1'b0;
    emit        = 1'b0;

    // step sequencing
    case (cw.jump)
      J_NEXT: upc_d = upc_q + 1'b1;
      J_GOTO: upc_d = cw.target;
      J_LOOP: begin
        if (w_q != WHEEL_W'(WHEELS - 1)) begin
          w_d   = w_q + 1'b1;
          upc_d = cw.target;
        end else begin
          w_d   = '0;
          upc_d = upc_q + 1'b1;
        end
      end
      J_BUSY: upc_d = div_sts.busy ? cw.target : upc_q + 1'b1;
      J_IN:   upc_d = cmd_fire ? upc_q + 1'b1 : upc_q;
      J_OUT: begin
        if (!out_valid_q || pulse_o.ready) begin
          emit  = 1'b1;
          upc_d = cw.target;
        end
      end
      J_OP: begin
        case (op_q)
          OP_STOP: upc_d = A_STOP;
          OP_MOVE: upc_d = A_ANGLE;
          OP_TURN: upc_d = A_MUL;
          default: upc_d = A_DONE;
        endcase
      end
      default: upc_d = A_IDLE;
    endcase

    // datapath operation
    case (cw.uop)
      U_LATCH: begin
        if (cmd_fire) begin
          op_d   = cmd_i.op;
          hmod_d = hmod_n;
          spd_d  = spd_n;
          left_d = cmd_i.turn_left;
        end
      end
      U_DISPATCH: begin
        mag_d = '0;
        w_d   = '0;
      end
      U_STOP: begin
        for (int i = 0; i < WHEELS; i++) pulse_d[i] = PULSE_W'(PULSE_MID);
      end
      U_ANGLE: theta_d = theta_n;
      U_SINE: begin
        v_d[w_q] = vs;
        if (sval > mag_q) mag_d = sval;
      end
      U_MUL:    prod_d = mul_p;
      U_DSTART: begin
        div_start = is_move;
        neg_d     = prod_neg;
        tq_d      = recip_p[RECIP_SHIFT +: QUOT_W];
      end
      U_WB:     pulse_d[w_q] = wb_val;
      U_EMIT: begin
        if (emit) begin
          out_d       = pulse_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // control state and wheel pulses under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= A_IDLE;
      w_q         <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < WHEELS; i++) pulse_q[i] <= PULSE_W'(PULSE_MID);
    end else begin
      upc_q       <= upc_d;
      w_q         <= w_d;
      out_valid_q <= out_valid_d;
      pulse_q     <= pulse_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    op_q    <= op_d;
    hmod_q  <= hmod_d;
    spd_q   <= spd_d;
    left_q  <= left_d;
    theta_q <= theta_d;
    v_q     <= v_d;
    mag_q   <= mag_d;
    prod_q  <= prod_d;
    neg_q   <= neg_d;
    tq_q    <= tq_d;
    out_q   <= out_d;
  end

  // shared divider
  mwcm_div #(
    .DVD_W (DVD_W),
    .DVS_W (SW),
    .QW    (QUOT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .quotient_o (div_quot),
    .sts_o      (div_sts)
  );

  // result channel
  assign pulse_o.valid          = out_valid_q;
  assign pulse_o.front_left_us  = out_q[0];
  assign pulse_o.front_right_us = out_q[1];
  assign pulse_o.back_left_us   = out_q[2];
  assign pulse_o.back_right_us  = out_q[3];

  // stored pulses never leave the servo range
  a_pulse_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pulse_q[0] >= PULSE_W'(PULSE_LOW)) && (pulse_q[0] <= PULSE_W'(PULSE_HIGH)) &&
    (pulse_q[1] >= PULSE_W'(PULSE_LOW)) && (pulse_q[1] <= PULSE_W'(PULSE_HIGH)) &&
    (pulse_q[2] >= PULSE_W'(PULSE_LOW)) && (pulse_q[2] <= PULSE_W'(PULSE_HIGH)) &&
    (pulse_q[3] >= PULSE_W'(PULSE_LOW)) && (pulse_q[3] <= PULSE_W'(PULSE_HIGH)))
    else $error("wheel pulse out of range");

  // divider is never restarted mid-run
  a_div_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> !div_sts.busy)
    else $error("divider started while busy");

  // on a move the wait step always sees a running divider right after a start
  a_div_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((upc_q == A_DSTART) && is_move) |=> (div_sts.busy && (upc_q == A_DWAIT)))
    else $error("divider not running after start");

  // move scaling never exceeds full gain
  a_move_quot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((upc_q == A_WB) && is_move) |-> (div_quot <= QUOT_W'(MOVE_MAX)))
    else $error("move quotient above full scale");

endmodule
